// ===== src/mep_pkg.sv =====
// shared types, constants and palette table for the mandelbrot escape pixel unit
`timescale 1ns / 1ps
package mep_pkg;

  localparam int COLUMN_W   = 10;
  localparam int ROW_W      = 9;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int STEP_W     = 31;
  localparam int COLOR_W    = 3;
  localparam int ITER_OUT_W = 7;
  localparam int ITER_W     = 8;
  localparam int OFF_W      = 12;
  localparam int CPROD_W    = 43;
  localparam int ZW         = 48;
  localparam int PW         = 64;
  localparam int OPW        = 32;
  localparam int PAL_SIZE   = 100;
  localparam int PAL_IDX_W  = 7;
  localparam int RE_SHIFT   = 28;
  localparam int IM_SHIFT   = 27;

  localparam logic [STEP_W-1:0] STEP_RESET = 31'd671089;

  localparam logic signed [ZW-1:0] Z_LIMIT_P = 48'sd536870912;
  localparam logic signed [ZW-1:0] Z_LIMIT_N = -48'sd536870912;
  localparam logic signed [PW-1:0] SQ_LIMIT  = 64'sd288230376151711744;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_STEP  = 3'd0,
    CFG_CENTER_REAL = 3'd1,
    CFG_CENTER_IMAG = 3'd2,
    CFG_START_REAL  = 3'd3,
    CFG_START_IMAG  = 3'd4,
    CFG_HIGH_DETAIL = 3'd5
  } cfg_index_e;

  typedef struct packed {
    logic              load;
    logic              cset;
    logic              mul;
    logic              upd;
    logic              emit;
    logic              esc;
    logic [ITER_W-1:0] iter;
    logic              high;
  } mep_cmd_t;

  typedef struct packed {
    logic abs_big;
    logic sq_big;
  } mep_status_t;

  localparam logic [COLOR_W-1:0] PALETTE [PAL_SIZE] = '{
    3'd1, 3'd7, 3'd7, 3'd6, 3'd6, 3'd6, 3'd5, 3'd5, 3'd4, 3'd4,
    3'd4, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd7,
    3'd7, 3'd7, 3'd6, 3'd6, 3'd6, 3'd5, 3'd5, 3'd5, 3'd4, 3'd4,
    3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd7, 3'd7, 3'd7, 3'd6, 3'd6, 3'd6, 3'd5, 3'd5, 3'd5, 3'd4,
    3'd4, 3'd4, 3'd4, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd1, 3'd1, 3'd1, 3'd7, 3'd7, 3'd7, 3'd7, 3'd6, 3'd6, 3'd6,
    3'd6, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
  };

  function automatic logic [COLOR_W-1:0] palette_color(input logic [ITER_W-1:0] it);
    logic [PAL_IDX_W-1:0] idx;
    idx = (it < ITER_W'(PAL_SIZE)) ? it[PAL_IDX_W-1:0] : PAL_IDX_W'(PAL_SIZE - 1);
    return PALETTE[idx];
  endfunction

endpackage

// ===== src/mep_ctrl.sv =====
// iteration controller: request handshake, iteration count and escape bookkeeping
`timescale 1ns / 1ps
module mep_ctrl #(
  parameter int LOW_DEPTH  = 50,
  parameter int HIGH_DEPTH = 100
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  logic                 high_detail_i,
  input  mep_pkg::mep_status_t status_i,
  output mep_pkg::mep_cmd_t    cmd_o
);
  import mep_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CSET,
    ST_MUL,
    ST_UPD,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [ITER_W-1:0] k_q;
  logic [ITER_W-1:0] depth_q;
  logic [ITER_W-1:0] iter_q;
  logic              first_q;
  logic              esc_q;
  logic              hd_q;
  logic              out_valid_q;
  logic [ITER_W-1:0] depth_d;
  mep_cmd_t          cmd;

  assign depth_d = high_detail_i ? ITER_W'(HIGH_DEPTH) : ITER_W'(LOW_DEPTH);

  always_comb begin
    cmd      = '0;
    cmd.esc  = esc_q;
    cmd.iter = iter_q;
    cmd.high = hd_q;
    case (state_q)
      ST_IDLE: cmd.load = in_valid_i;
      ST_CSET: cmd.cset = 1'b1;
      ST_MUL:  cmd.mul  = first_q || !status_i.abs_big;
      ST_UPD:  cmd.upd  = (first_q || !status_i.sq_big) && (k_q != depth_q);
      ST_DONE: cmd.emit = !out_valid_q || !out_stall_i;
      default: cmd      = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      depth_q     <= ITER_W'(LOW_DEPTH);
      iter_q      <= '0;
      first_q     <= 1'b1;
      esc_q       <= 1'b0;
      hd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd.load) begin
            k_q     <= '0;
            first_q <= 1'b1;
            esc_q   <= 1'b0;
            depth_q <= depth_d;
            hd_q    <= high_detail_i;
            state_q <= ST_CSET;
          end
        end
        ST_CSET: state_q <= ST_MUL;
        ST_MUL: begin
          if (cmd.mul) begin
            state_q <= ST_UPD;
          end else begin
            esc_q   <= 1'b1;
            iter_q  <= k_q - ITER_W'(1);
            state_q <= ST_DONE;
          end
        end
        ST_UPD: begin
          if (!first_q && status_i.sq_big) begin
            esc_q   <= 1'b1;
            iter_q  <= k_q - ITER_W'(1);
            state_q <= ST_DONE;
          end else if (k_q == depth_q) begin
            esc_q   <= 1'b0;
            iter_q  <= depth_q;
            state_q <= ST_DONE;
          end else begin
            k_q     <= k_q + ITER_W'(1);
            first_q <= 1'b0;
            state_q <= ST_MUL;
          end
        end
        ST_DONE: begin
          if (cmd.emit) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign cmd_o       = cmd;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_k_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= depth_q)
    else $error("iteration count beyond depth");

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && state_q == ST_CSET))
    else $error("accepted request did not start the point setup");

  a_escape_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && esc_q) |-> (iter_q < depth_q))
    else $error("escape iteration not below depth");

  a_first_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && first_q) |-> (k_q == '0))
    else $error("first pass flag out of step with count");

endmodule

// ===== src/mep_dp.sv =====
// datapath: point mapping, shared complex squaring multipliers, escape test, result register
`timescale 1ns / 1ps
module mep_dp #(
  parameter int IMAGE_WIDTH  = 800,
  parameter int IMAGE_HEIGHT = 480
) (
  input  logic                                clk_i,
  input  logic [mep_pkg::COLUMN_W-1:0]        column_i,
  input  logic [mep_pkg::ROW_W-1:0]           row_index_i,
  input  logic [mep_pkg::STEP_W-1:0]          pixel_step_i,
  input  logic signed [mep_pkg::CFG_W-1:0]    center_real_i,
  input  logic signed [mep_pkg::CFG_W-1:0]    center_imag_i,
  input  logic signed [mep_pkg::CFG_W-1:0]    start_real_i,
  input  logic signed [mep_pkg::CFG_W-1:0]    start_imag_i,
  input  mep_pkg::mep_cmd_t                   cmd_i,
  output mep_pkg::mep_status_t                status_o,
  output logic [mep_pkg::COLOR_W-1:0]         pixel_color_o,
  output logic [mep_pkg::ITER_OUT_W-1:0]      escape_iteration_o,
  output logic                                escaped_o
);
  import mep_pkg::*;

  logic signed [OFF_W-1:0]   col_off_q;
  logic signed [OFF_W-1:0]   row_off_q;
  logic signed [OFF_W-1:0]   col_off_d;
  logic signed [OFF_W-1:0]   row_off_d;
  logic signed [CPROD_W-1:0] cr_prod;
  logic signed [CPROD_W-1:0] ci_prod;
  logic signed [ZW-1:0]      cr_q;
  logic signed [ZW-1:0]      ci_q;
  logic signed [ZW-1:0]      zr_q;
  logic signed [ZW-1:0]      zi_q;
  logic signed [ZW-1:0]      zr_d;
  logic signed [ZW-1:0]      zi_d;
  logic signed [OPW-1:0]     opr;
  logic signed [OPW-1:0]     opi;
  logic signed [PW-1:0]      rr_q;
  logic signed [PW-1:0]      ii_q;
  logic signed [PW-1:0]      ri_q;
  logic signed [PW-1:0]      diff;
  logic [COLOR_W-1:0]        color_q;
  logic [ITER_OUT_W-1:0]     iter_out_q;
  logic                      escaped_q;
  logic [COLOR_W-1:0]        color_d;

  assign col_off_d = $signed({2'b00, column_i}) - OFF_W'(IMAGE_WIDTH / 2);
  assign row_off_d = $signed({3'b000, row_index_i}) - OFF_W'(IMAGE_HEIGHT / 2);

  assign cr_prod = col_off_q * $signed({1'b0, pixel_step_i});
  assign ci_prod = row_off_q * $signed({1'b0, pixel_step_i});

  // operands fit 32 bits: start values, or z that passed the magnitude check
  assign opr = zr_q[OPW-1:0];
  assign opi = zi_q[OPW-1:0];

  assign diff = rr_q - ii_q;
  assign zr_d = ZW'(diff >>> RE_SHIFT) + cr_q;
  assign zi_d = ZW'(ri_q >>> IM_SHIFT) + ci_q;

  assign status_o.abs_big = (zr_q > Z_LIMIT_P) || (zr_q < Z_LIMIT_N) ||
                            (zi_q > Z_LIMIT_P) || (zi_q < Z_LIMIT_N);
  assign status_o.sq_big  = (rr_q + ii_q) > SQ_LIMIT;

  always_comb begin
    if (!cmd_i.esc) begin
      color_d = '0;
    end else if (!cmd_i.high) begin
      color_d = COLOR_W'(1);
    end else begin
      color_d = palette_color(cmd_i.iter);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      col_off_q <= col_off_d;
      row_off_q <= row_off_d;
    end
    if (cmd_i.cset) begin
      cr_q <= ZW'(center_real_i) + ZW'(cr_prod);
      ci_q <= ZW'(center_imag_i) + ZW'(ci_prod);
      zr_q <= ZW'(start_real_i);
      zi_q <= ZW'(start_imag_i);
    end else if (cmd_i.upd) begin
      zr_q <= zr_d;
      zi_q <= zi_d;
    end
    if (cmd_i.mul) begin
      rr_q <= opr * opr;
      ii_q <= opi * opi;
      ri_q <= opr * opi;
    end
    if (cmd_i.emit) begin
      color_q    <= color_d;
      iter_out_q <= cmd_i.iter[ITER_OUT_W-1:0];
      escaped_q  <= cmd_i.esc;
    end
  end

  assign pixel_color_o      = color_q;
  assign escape_iteration_o = iter_out_q;
  assign escaped_o          = escaped_q;

endmodule

// ===== src/mandelbrot_escape_pixel_unit.sv =====
// top level: configuration registers, controller and datapath of the escape pixel unit
`timescale 1ns / 1ps
// One request carries a pixel column and row; one result comes back with the
// palette color, the escape iteration and the escaped flag. Each iteration of
// z = z*z + c has a multiply step that registers the three 32x32 products of
// the shared multiplier set and an update step that adds c and tests the
// magnitude. One pixel is worked on at a time; the next request is taken as
// soon as the result is in the output register, even while that result still
// waits to be taken.
// Configuration writes should be made while no pixel is in flight.
module mandelbrot_escape_pixel_unit #(
  parameter int IMAGE_WIDTH  = 800,
  parameter int IMAGE_HEIGHT = 480,
  parameter int LOW_DEPTH    = 50,
  parameter int HIGH_DEPTH   = 100
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mep_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mep_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [mep_pkg::COLUMN_W-1:0]       column_i,
  input  logic [mep_pkg::ROW_W-1:0]          row_index_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [mep_pkg::COLOR_W-1:0]        pixel_color_o,
  output logic [mep_pkg::ITER_OUT_W-1:0]     escape_iteration_o,
  output logic                               escaped_o
);
  import mep_pkg::*;

  logic [STEP_W-1:0]       pixel_step_q;
  logic signed [CFG_W-1:0] center_real_q;
  logic signed [CFG_W-1:0] center_imag_q;
  logic signed [CFG_W-1:0] start_real_q;
  logic signed [CFG_W-1:0] start_imag_q;
  logic                    high_detail_q;
  mep_cmd_t                cmd;
  mep_status_t             status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_step_q  <= STEP_RESET;
      center_real_q <= '0;
      center_imag_q <= '0;
      start_real_q  <= '0;
      start_imag_q  <= '0;
      high_detail_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PIXEL_STEP:  pixel_step_q  <= cfg_wdata_i[STEP_W-1:0];
        CFG_CENTER_REAL: center_real_q <= $signed(cfg_wdata_i);
        CFG_CENTER_IMAG: center_imag_q <= $signed(cfg_wdata_i);
        CFG_START_REAL:  start_real_q  <= $signed(cfg_wdata_i);
        CFG_START_IMAG:  start_imag_q  <= $signed(cfg_wdata_i);
        CFG_HIGH_DETAIL: high_detail_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  mep_ctrl #(
    .LOW_DEPTH  (LOW_DEPTH),
    .HIGH_DEPTH (HIGH_DEPTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .high_detail_i (high_detail_q),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  mep_dp #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_dp (
    .clk_i              (clk_i),
    .column_i           (column_i),
    .row_index_i        (row_index_i),
    .pixel_step_i       (pixel_step_q),
    .center_real_i      (center_real_q),
    .center_imag_i      (center_imag_q),
    .start_real_i       (start_real_q),
    .start_imag_i       (start_imag_q),
    .cmd_i              (cmd),
    .status_o           (status),
    .pixel_color_o      (pixel_color_o),
    .escape_iteration_o (escape_iteration_o),
    .escaped_o          (escaped_o)
  );

endmodule

// ===== sim/mandelbrot_escape_pixel_unit_test.sv =====
// self-checking testbench for the mandelbrot escape pixel unit
`timescale 1ns / 1ps
module mandelbrot_escape_pixel_unit_test;
  import mep_pkg::*;

  localparam int IMAGE_WIDTH  = 800;
  localparam int IMAGE_HEIGHT = 480;
  localparam int LOW_DEPTH    = 50;
  localparam int HIGH_DEPTH   = 100;

  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] SPARE_INDEX_B = 3'd7;

  localparam longint ESCAPE_EDGE      = 64'sd536870912;
  localparam longint ESCAPE_RADIUS_SQ = 64'sd288230376151711744;
  localparam logic [CFG_W-1:0] UNIT_Q28 = 32'h1000_0000;

  localparam int RANDOM_PHASES   = 8;
  localparam int PIXELS_PER_VIEW = 235;
  localparam int HOLD_AT         = 700;
  localparam int HOLD_CYCLES     = 1200;
  localparam int CYCLE_LIMIT     = 2000000;
  localparam int MAX_REPORTS     = 10;

  localparam int HUE_TABLE [100] = '{
    1, 7, 7, 6, 6, 6, 5, 5, 4, 4, 4, 3, 3, 3, 2, 2, 1, 1, 1, 7,
    7, 7, 6, 6, 6, 5, 5, 5, 4, 4, 3, 3, 3, 2, 2, 2, 1, 1, 1, 1,
    7, 7, 7, 6, 6, 6, 5, 5, 5, 4, 4, 4, 4, 3, 3, 3, 2, 2, 2, 2,
    1, 1, 1, 7, 7, 7, 7, 6, 6, 6, 6, 5, 5, 5, 5, 5, 4, 4, 4, 4,
    3, 3, 3, 3, 3, 2, 2, 2, 2, 2, 2, 1, 1, 1, 1, 1, 1, 1, 1, 1
  };

  typedef struct packed {
    logic [COLUMN_W-1:0] column;
    logic [ROW_W-1:0]    row_index;
  } pixel_request_t;

  typedef struct packed {
    logic [COLOR_W-1:0]    color;
    logic [ITER_OUT_W-1:0] iteration;
    logic                  escaped;
  } pixel_result_t;

  typedef struct packed {
    pixel_request_t request;
    pixel_result_t  result;
  } pending_pixel_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_W-1:0]       cfg_wdata_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [COLUMN_W-1:0]    column_i = '0;
  logic [ROW_W-1:0]       row_index_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [COLOR_W-1:0]     pixel_color_o;
  logic [ITER_OUT_W-1:0]  escape_iteration_o;
  logic                   escaped_o;

  // view settings as the block should hold them
  logic [STEP_W-1:0] view_step = STEP_RESET;
  longint            view_center_re = 0;
  longint            view_center_im = 0;
  longint            view_start_re = 0;
  longint            view_start_im = 0;
  logic              high_mode = 1'b0;

  pixel_request_t pixel_queue [$];
  pending_pixel_t expected_pixels [$];

  int  pixels_queued = 0;
  int  req_count = 0;
  logic req_done = 1'b0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  logic idle_on = 1'b1;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  logic hold_done = 1'b0;

  mandelbrot_escape_pixel_unit #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT),
    .LOW_DEPTH   (LOW_DEPTH),
    .HIGH_DEPTH  (HIGH_DEPTH)
  ) i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .column_i          (column_i),
    .row_index_i       (row_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .pixel_color_o     (pixel_color_o),
    .escape_iteration_o(escape_iteration_o),
    .escaped_o         (escaped_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic pixel_result_t escape_time(input pixel_request_t px);
    pixel_result_t r;
    longint c_re, c_im, z_re, z_im, sq_re, sq_im, cross_prod;
    int depth, n, hue_idx;
    logic hit;
    c_re = view_center_re + (longint'(px.column) - IMAGE_WIDTH / 2) * longint'(view_step);
    c_im = view_center_im + (longint'(px.row_index) - IMAGE_HEIGHT / 2) * longint'(view_step);
    z_re = view_start_re;
    z_im = view_start_im;
    depth = high_mode ? HIGH_DEPTH : LOW_DEPTH;
    hit = 1'b0;
    n = 0;
    while (!hit && n < depth) begin
      sq_re = z_re * z_re;
      sq_im = z_im * z_im;
      cross_prod = z_re * z_im;
      z_re = ((sq_re - sq_im) >>> RE_SHIFT) + c_re;
      z_im = (cross_prod >>> IM_SHIFT) + c_im;
      // large parts escape before any squaring
      if (z_re > ESCAPE_EDGE || z_re < -ESCAPE_EDGE || z_im > ESCAPE_EDGE || z_im < -ESCAPE_EDGE) begin
        hit = 1'b1;
      end else if (z_re * z_re + z_im * z_im > ESCAPE_RADIUS_SQ) begin
        hit = 1'b1;
      end
      if (!hit) begin
        n = n + 1;
      end
    end
    hue_idx = (n < 100) ? n : 99;
    r.escaped = hit;
    r.iteration = n[ITER_OUT_W-1:0];
    if (!hit) begin
      r.color = '0;
    end else if (!high_mode) begin
      r.color = 3'd1;
    end else begin
      r.color = HUE_TABLE[hue_idx][COLOR_W-1:0];
    end
    return r;
  endfunction

  // request driver
  always @(negedge clk_i) begin : request_driver
    pixel_request_t nxt;
    logic drive_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_done) begin
      drive_valid = 1'b0;
      if (send_gap > 0) begin
        send_gap = send_gap - 1;
      end else if (pixel_queue.size() > 0) begin
        nxt = pixel_queue.pop_front();
        column_i <= nxt.column;
        row_index_i <= nxt.row_index;
        drive_valid = 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0) begin
          send_gap = $urandom_range(1, 15);
        end
      end
      in_valid_i <= drive_valid;
    end
  end

  // long receiver hold-off once traffic is well under way
  always @(negedge clk_i) begin
    if (!hold_done && req_count >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 15);
      end
      out_stall_i <= (stall_left > 0) || (hold_left > 0);
    end
  end

  // request and result monitor
  always @(posedge clk_i) begin : monitor
    pending_pixel_t entry;
    pixel_request_t px;
    req_done = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        px.column = column_i;
        px.row_index = row_index_i;
        entry.request = px;
        entry.result = escape_time(px);
        expected_pixels.push_back(entry);
        req_count = req_count + 1;
        req_done = 1'b1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_pixels.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected result: color %0d iteration %0d escaped %0b",
                     pixel_color_o, escape_iteration_o, escaped_o);
          end
        end else begin
          entry = expected_pixels.pop_front();
          if (pixel_color_o !== entry.result.color ||
              escape_iteration_o !== entry.result.iteration ||
              escaped_o !== entry.result.escaped) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("mismatch at column %0d row %0d: expected color %0d iteration %0d escaped %0b, got color %0d iteration %0d escaped %0b",
                       entry.request.column, entry.request.row_index,
                       entry.result.color, entry.result.iteration, entry.result.escaped,
                       pixel_color_o, escape_iteration_o, escaped_o);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_PIXEL_STEP:  view_step = data[STEP_W-1:0];
      CFG_CENTER_REAL: view_center_re = $signed(data);
      CFG_CENTER_IMAG: view_center_im = $signed(data);
      CFG_START_REAL:  view_start_re = $signed(data);
      CFG_START_IMAG:  view_start_im = $signed(data);
      CFG_HIGH_DETAIL: high_mode = data[0];
      default: ;
    endcase
  endtask

  task automatic set_view(input logic [CFG_W-1:0] step, input logic [CFG_W-1:0] cre,
                          input logic [CFG_W-1:0] cim, input logic [CFG_W-1:0] sre,
                          input logic [CFG_W-1:0] sim, input logic [CFG_W-1:0] detail);
    write_register(CFG_PIXEL_STEP, step);
    write_register(CFG_CENTER_REAL, cre);
    write_register(CFG_CENTER_IMAG, cim);
    write_register(CFG_START_REAL, sre);
    write_register(CFG_START_IMAG, sim);
    write_register(CFG_HIGH_DETAIL, detail);
    // spare indexes must leave the view alone
    write_register(SPARE_INDEX_A, $urandom);
    write_register(SPARE_INDEX_B, $urandom);
  endtask

  task automatic queue_pixel(input int col, input int row);
    pixel_request_t px;
    px.column = col[COLUMN_W-1:0];
    px.row_index = row[ROW_W-1:0];
    pixel_queue.push_back(px);
    pixels_queued = pixels_queued + 1;
  endtask

  task automatic wait_results_idle();
    while (req_count != pixels_queued || expected_pixels.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [CFG_W-1:0] near_origin(input int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  initial begin : stimulus
    int ph, k;
    logic [CFG_W-1:0] step, cre, cim, sre, sim;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset view, low detail
    queue_pixel(0, 0);
    queue_pixel(799, 479);
    queue_pixel(1023, 511);
    queue_pixel(IMAGE_WIDTH / 2, IMAGE_HEIGHT / 2);
    queue_pixel(200, 100);
    wait_results_idle();

    // default zoom in high detail for a spread of escape iterations
    set_view(32'd671089, '0, '0, '0, '0, 32'd1);
    queue_pixel(0, 0);
    queue_pixel(IMAGE_WIDTH / 2, IMAGE_HEIGHT / 2);
    queue_pixel(100, 240);
    queue_pixel(300, 240);
    queue_pixel(520, 300);
    queue_pixel(1023, 0);
    wait_results_idle();

    // c = 2 lands exactly on the radius before escaping
    set_view('0, 2 * UNIT_Q28, '0, '0, '0, 32'd1);
    queue_pixel(0, 0);
    queue_pixel(1023, 511);
    wait_results_idle();

    // register extremes, masked step and detail bit
    set_view(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'hFFFF_FFFE);
    queue_pixel(0, 0);
    queue_pixel(1023, 511);
    queue_pixel(IMAGE_WIDTH / 2, IMAGE_HEIGHT / 2);
    wait_results_idle();

    set_view(32'd1, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1);
    queue_pixel(IMAGE_WIDTH / 2, IMAGE_HEIGHT / 2);
    queue_pixel(0, 511);
    wait_results_idle();

    // nonzero start point near the origin
    set_view(32'd671089, '0, '0, UNIT_Q28 / 4, '0, 32'd1);
    queue_pixel(400, 240);
    queue_pixel(399, 239);
    queue_pixel(401, 241);
    wait_results_idle();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_on = (ph != RANDOM_PHASES - 1);
      if (ph == 3) begin
        step = $urandom;
        cre = $urandom;
        cim = $urandom;
      end else begin
        step = $urandom_range(100, 3000000);
        cre = near_origin(2 * UNIT_Q28);
        cim = near_origin(UNIT_Q28);
      end
      if (ph % 3 == 2) begin
        sre = near_origin(UNIT_Q28 / 2);
        sim = near_origin(UNIT_Q28 / 2);
      end else begin
        sre = '0;
        sim = '0;
      end
      set_view(step, cre, cim, sre, sim, ($urandom & ~32'd1) | ph[0]);
      for (k = 0; k < PIXELS_PER_VIEW; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          queue_pixel($urandom_range(0, 1023), $urandom_range(0, 511));
        end else begin
          queue_pixel($urandom_range(0, IMAGE_WIDTH - 1), $urandom_range(0, IMAGE_HEIGHT - 1));
        end
      end
      wait_results_idle();
    end

    repeat (2 * HIGH_DEPTH + 8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
